/* rtl/crcfp_pkg.sv */
// Shared types, constants and the reflected CRC-8 byte update for the frame parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package crcfp_pkg;

    localparam logic [7:0] SYNC_FIRST       = 8'hAA;
    localparam logic [7:0] SYNC_SECOND      = 8'h55;
    localparam logic [7:0] CRC_POLY_REFL    = 8'h8C;
    localparam logic [7:0] FUNC_COUNT_RESET = 8'd16;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_FUNC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRC   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    // A received byte together with the flags the front end derives from it.
    typedef struct packed {
        logic [7:0] data;
        logic       is_sync1;
        logic       is_sync2;
        logic       is_zero;
        logic       func_ok;
    } t_cls;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] func_code;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
    } t_res;

    // One byte of reflected CRC-8 with polynomial 0x31, shifted right bit by bit.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/crc8_frame_parser_top.sv */
// Top level of the sync-header frame parser with a reflected CRC-8 check.
// Instantiates crcfp_front, crcfp_queue and crcfp_back; depends on crcfp_pkg.
// Received bytes enter through a queue-style port: a byte is taken at a rising
// edge where push is high and full is low. Results leave through a second
// queue-style port: while empty is low the oldest result is on o_kind,
// o_func_code, o_payload_byte, o_byte_index and o_frame_length, and it is
// removed at an edge where pop is high. The function count register is
// written through its own valid/ready channel; ready is always high, and a
// write is only expected while no request is still in flight.
// Each payload byte yields one result, the checksum byte yields one frame-end
// result (good or bad CRC), every other byte yields none.
// A result reaches the output ports through the front register, then the middle
// queue, then the result queue of the back end, each of which is registered.
// Throughput: one byte per cycle sustained while the receiver keeps taking results,
// set by the state machine and CRC step in the back end.
// When the receiver stalls, up to two results wait in the output queue, two
// bytes in the middle queue and one in the front register; after that full
// rises and input requests are held off until pop drains a result.
// Reset (synchronous, active low) empties all queues, returns the parser to
// hunting the first sync byte and loads the function count with 16.
`default_nettype none

module crc8_frame_parser_top
    import crcfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_rx_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_func_code,
    output logic [7:0]      o_payload_byte,
    output logic [7:0]      o_byte_index,
    output logic [7:0]      o_frame_length,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic q_push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cls q_in_item;
    t_cls q_out_item;
    t_res res;

    // Front end: takes the byte request and tags sync bytes, zero length and
    // accepted function codes against the configured count.
    crcfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_q_push    (q_push),
        .o_q_item    (q_in_item),
        .i_q_full    (q_full)
    );

    // The short queue lets the front keep taking bytes while the back waits.
    crcfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_out_item),
        .i_pop   (q_pop)
    );

    // Back end: frame state machine, running CRC and the result queue.
    crcfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (q_out_item),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_res     (res)
    );

    assign o_kind         = res.kind;
    assign o_func_code    = res.func_code;
    assign o_payload_byte = res.payload_byte;
    assign o_byte_index   = res.byte_index;
    assign o_frame_length = res.frame_length;

endmodule

`default_nettype wire

/* rtl/crcfp_front.sv */
// Front end of the frame parser: takes received bytes, holds the function count
// register and classifies each byte. Depends on crcfp_pkg.
`default_nettype none

module crcfp_front
    import crcfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    output logic            o_q_push,
    output t_cls            o_q_item,
    input  wire logic       i_q_full
);

    logic [7:0] r_func_count;
    logic       r_valid;
    logic       n_valid;
    t_cls       r_item;
    logic       accept;

    assign o_cfg_ready = 1'b1;
    assign full        = r_valid && i_q_full;
    assign accept      = push && !full;
    assign o_q_push    = r_valid && !i_q_full;
    assign o_q_item    = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_func_count <= FUNC_COUNT_RESET;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_func_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data     <= i_rx_byte;
            r_item.is_sync1 <= (i_rx_byte == SYNC_FIRST);
            r_item.is_sync2 <= (i_rx_byte == SYNC_SECOND);
            r_item.is_zero  <= (i_rx_byte == 8'd0);
            r_item.func_ok  <= (i_rx_byte < r_func_count);
        end
    end

endmodule

`default_nettype wire

/* rtl/crcfp_queue.sv */
// Two-entry queue of classified bytes between the front end and the back end.
// Depends on crcfp_pkg.
`default_nettype none

module crcfp_queue
    import crcfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_item,
    output logic      o_full,
    output logic      o_empty,
    output t_cls      o_item,
    input  wire logic i_pop
);

    t_cls       r_mem [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/crcfp_back.sv */
// Back end of the frame parser: frame state machine, running CRC and the
// two-entry result queue that drives the result ports. Depends on crcfp_pkg.
`default_nettype none

module crcfp_back
    import crcfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_cls i_q_item,
    output logic      o_q_pop,
    output logic      empty,
    input  wire logic pop,
    output t_res      o_res
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [7:0] r_func;
    logic [7:0] n_func;
    logic [7:0] r_len;
    logic [7:0] n_len;
    logic [7:0] r_rcv;
    logic [7:0] n_rcv;
    logic [7:0] rcv_inc;
    logic       step;
    logic       emit;
    t_res       res;

    t_res       r_oq [2];
    logic       r_ord;
    logic       r_owr;
    logic [1:0] r_ocnt;
    logic       out_full;
    logic       out_pop;

    assign out_full = (r_ocnt == 2'd2);
    assign out_pop  = pop && !empty;
    assign empty    = (r_ocnt == 2'd0);
    assign o_res    = r_oq[r_ord];
    assign step     = !i_q_empty && !out_full;
    assign o_q_pop  = step;
    assign rcv_inc  = r_rcv + 8'd1;

    // Next state of the frame tracker.
    always_comb begin
        n_phase = r_phase;
        n_crc   = r_crc;
        n_func  = r_func;
        n_len   = r_len;
        n_rcv   = r_rcv;
        if (step) begin
            case (r_phase)
                PH_SYNC2: begin
                    n_phase = i_q_item.is_sync2 ? PH_FUNC : PH_SYNC1;
                end
                PH_FUNC: begin
                    if (i_q_item.func_ok) begin
                        n_func  = i_q_item.data;
                        n_len   = 8'd0;
                        n_crc   = crc8_update(8'd0, i_q_item.data);
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_LEN: begin
                    n_len   = i_q_item.data;
                    n_rcv   = 8'd0;
                    n_crc   = crc8_update(r_crc, i_q_item.data);
                    n_phase = i_q_item.is_zero ? PH_CRC : PH_DATA;
                end
                PH_DATA: begin
                    n_crc = crc8_update(r_crc, i_q_item.data);
                    n_rcv = rcv_inc;
                    if (rcv_inc >= r_len) begin
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    n_phase = PH_SYNC1;
                end
                default: begin
                    n_phase = i_q_item.is_sync1 ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    // Result produced by the byte being processed.
    always_comb begin
        emit             = 1'b0;
        res.kind         = KIND_DATA;
        res.func_code    = r_func;
        res.payload_byte = 8'd0;
        res.byte_index   = 8'd0;
        res.frame_length = r_len;
        case (r_phase)
            PH_DATA: begin
                emit             = step;
                res.payload_byte = i_q_item.data;
                res.byte_index   = r_rcv;
            end
            PH_CRC: begin
                emit     = step;
                res.kind = (r_crc == i_q_item.data) ? KIND_GOOD : KIND_BAD;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_crc   <= 8'd0;
            r_func  <= 8'd0;
            r_len   <= 8'd0;
            r_rcv   <= 8'd0;
            r_ord   <= 1'b0;
            r_owr   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
            r_func  <= n_func;
            r_len   <= n_len;
            r_rcv   <= n_rcv;
            if (emit) begin
                r_owr <= ~r_owr;
            end
            if (out_pop) begin
                r_ord <= ~r_ord;
            end
            r_ocnt <= r_ocnt + 2'(emit) - 2'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oq[r_owr] <= res;
        end
    end

`ifndef ASSERT_OFF
    a_ocnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("result queue count out of range");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_rcv < r_len)
        else $error("payload count reached the frame length inside the payload");

    a_crc_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_phase == PH_CRC |=> r_phase == PH_SYNC1 && !empty)
        else $error("checksum byte did not end the frame with a result");
`endif

endmodule

`default_nettype wire

/* tb/sv/crc8_frame_parser_top_test.sv */
// Self-checking testbench for crc8_frame_parser_top: sync/length/CRC-8 frame parsing.
// Depends on crcfp_pkg for the phase and result kind enums and the sync byte constants.
// Holds a frame checker class that predicts every result and a module that drives the block.

import crcfp_pkg::*;

typedef logic [7:0] t_byte_q [$];

// Tracks the parser state on its own and keeps the results that accepted bytes must produce.
class frame_checker;
    logic [7:0] crc_table [256];
    logic [7:0] func_limit;
    t_phase     hunt_phase;
    logic [7:0] crc_acc;
    logic [7:0] cur_func;
    logic [7:0] cur_len;
    logic [7:0] payload_count;
    t_res       awaited_results [$];
    int         errors;

    function new();
        logic [7:0] r;
        for (int i = 0; i < 256; i++) begin
            r = 8'(i);
            repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
            crc_table[i] = r;
        end
        func_limit    = FUNC_COUNT_RESET;
        hunt_phase    = PH_SYNC1;
        crc_acc       = 8'h00;
        cur_func      = 8'h00;
        cur_len       = 8'h00;
        payload_count = 8'h00;
        errors        = 0;
    endfunction

    function logic [7:0] crc_next(logic [7:0] crc, logic [7:0] b);
        return crc_table[crc ^ b];
    endfunction

    function void set_func_limit(logic [7:0] v);
        func_limit = v;
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    function void await_result(t_kind k, logic [7:0] pb, logic [7:0] idx);
        t_res e;
        e.kind         = k;
        e.func_code    = cur_func;
        e.payload_byte = pb;
        e.byte_index   = idx;
        e.frame_length = cur_len;
        awaited_results = {awaited_results, e};
    endfunction

    // Advances the parser by one accepted input request.
    function void take_byte(logic [7:0] b);
        case (hunt_phase)
            PH_SYNC2: begin
                // A wrong second sync byte is dropped, even when it is itself a first sync byte.
                hunt_phase = (b == SYNC_SECOND) ? PH_FUNC : PH_SYNC1;
            end
            PH_FUNC: begin
                if (b < func_limit) begin
                    cur_func   = b;
                    cur_len    = 8'h00;
                    crc_acc    = crc_next(8'h00, b);
                    hunt_phase = PH_LEN;
                end else begin
                    hunt_phase = PH_SYNC1;
                end
            end
            PH_LEN: begin
                cur_len       = b;
                payload_count = 8'h00;
                crc_acc       = crc_next(crc_acc, b);
                hunt_phase    = (b == 8'h00) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
                crc_acc = crc_next(crc_acc, b);
                await_result(KIND_DATA, b, payload_count);
                payload_count++;
                if (payload_count >= cur_len) begin
                    hunt_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                await_result((crc_acc == b) ? KIND_GOOD : KIND_BAD, 8'h00, 8'h00);
                hunt_phase = PH_SYNC1;
            end
            default: begin
                hunt_phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Compares one accepted result request with the oldest awaited one.
    function void match_result(logic [1:0] kind, logic [7:0] func, logic [7:0] pb,
                               logic [7:0] idx, logic [7:0] len);
        t_res e;
        if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0h func %0h %0h %0h %0h",
                     $time, kind, func, pb, idx, len);
            return;
        end
        e = awaited_results[0];
        awaited_results.delete(0);
        compare_field("kind", e.kind, kind);
        compare_field("func_code", e.func_code, func);
        compare_field("payload_byte", e.payload_byte, pb);
        compare_field("byte_index", e.byte_index, idx);
        compare_field("frame_length", e.frame_length, len);
    endfunction
endclass

module crc8_frame_parser_top_test;

    // The run is far shorter than this; only a hung handshake gets near it.
    localparam int CYCLE_LIMIT  = 200000;
    // Lets bytes that yield no result pass the front register, the middle queue and the back end too.
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_rx_byte;
    logic       empty;
    logic       pop;
    logic [1:0] o_kind;
    logic [7:0] o_func_code;
    logic [7:0] o_payload_byte;
    logic [7:0] o_byte_index;
    logic [7:0] o_frame_length;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    frame_checker checker_h;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           cycle_count = 0;
    int           sent_items;
    t_byte_q      body;

    crc8_frame_parser_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_func_code    (o_func_code),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver decides afresh every cycle whether it takes the head result.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Both handshakes are sampled at the clock edge, before any of this edge's updates land,
    // so the checker sees exactly the requests that the block accepts.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                checker_h.take_byte(i_rx_byte);
            end
            if (pop && !empty) begin
                checker_h.match_result(o_kind, o_func_code, o_payload_byte, o_byte_index,
                                       o_frame_length);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("crc8_frame_parser_top regression: fail");
            $finish;
        end
    end

    // Offers one byte, with random idle cycles ahead of it, and returns at the edge that
    // takes it. Push stays high so that a following byte can go out back to back.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            push      <= 1'b0;
            i_rx_byte <= 8'($urandom);
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Sends a whole frame around the given payload; a bad checksum is off by a nonzero xor.
    task automatic send_frame(input logic [7:0] func, input t_byte_q payload,
                              input logic crc_ok);
        logic [7:0] crc;
        logic [7:0] len;
        len = 8'(payload.size());
        crc = checker_h.crc_next(8'h00, func);
        crc = checker_h.crc_next(crc, len);
        foreach (payload[i]) crc = checker_h.crc_next(crc, payload[i]);
        if (!crc_ok) begin
            crc = crc ^ 8'($urandom_range(255, 1));
        end
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(func);
        send_byte(len);
        foreach (payload[i]) send_byte(payload[i]);
        send_byte(crc);
        sent_items += 5 + payload.size();
    endtask

    function automatic t_byte_q random_payload(input int len);
        t_byte_q q;
        repeat (len) q = {q, 8'($urandom)};
        return q;
    endfunction

    // Stops sending and waits until every awaited result has been taken, then lets the
    // pipeline settle so that bytes that produce no result are through it as well.
    task automatic drain();
        push <= 1'b0;
        while (checker_h.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The function count is only changed while the parser has nothing in flight.
    task automatic write_func_count(input logic [7:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        checker_h.set_func_limit(v);
    endtask

    // Mostly well-formed frames with random content; the rest are rejected function codes,
    // broken sync pairs and loose noise bytes; only the noise bytes do not count toward the total.
    task automatic random_traffic(input int n_items);
        int         first;
        int         r;
        int         len;
        logic [7:0] lim;
        first = sent_items;
        while (sent_items - first < n_items) begin
            r   = $urandom_range(99, 0);
            lim = checker_h.func_limit;
            if (r < 75 && lim != 8'h00) begin
                r = $urandom_range(99, 0);
                if (r < 2) begin
                    len = $urandom_range(255, 200);
                end else if (r < 40) begin
                    len = $urandom_range(3, 0);
                end else if (r < 90) begin
                    len = $urandom_range(16, 4);
                end else begin
                    len = $urandom_range(64, 17);
                end
                send_frame(8'($urandom_range(lim - 1, 0)), random_payload(len),
                           $urandom_range(99, 0) < 85);
            end else if (r < 85) begin
                // A function code at or above the limit sends the parser back to hunting.
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(8'($urandom_range(255, lim)));
                sent_items += 3;
            end else if (r < 92) begin
                send_byte(SYNC_FIRST);
                r = $urandom_range(255, 0);
                send_byte((r == SYNC_SECOND) ? SYNC_FIRST : 8'(r));
                sent_items += 2;
            end else begin
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        checker_h      = new();
        sent_items     = 0;
        send_idle_pct  = 10;
        recv_stall_pct = 74;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_rx_byte      = 8'h00;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with the function count still at its reset value of 16.
        // Zero length with the lowest function code: the length byte leads straight to
        // the checksum, and the only result is a good frame end.
        body.delete();
        send_frame(8'h00, body, 1'b1);
        // The highest accepted code with extreme payload bytes and a corrupted checksum.
        body = '{8'h00, 8'hFF};
        send_frame(8'h0F, body, 1'b0);
        // A code equal to the limit is rejected and produces nothing.
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h10);
        // A first sync byte in place of the second one is dropped, not taken as a new
        // frame start, so the bytes after it are just hunted through.
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'hFF);
        // A good one-byte frame right after the noise shows that the parser recovered.
        body = '{8'hA5};
        send_frame(8'h07, body, 1'b1);
        sent_items += 9;

        // Each write below first holds the sender off until every awaited result is in.
        // A zero function count rejects every frame.
        write_func_count(8'h00);
        random_traffic(40);

        // The widest setting, opened by the longest frame at the highest usable code.
        write_func_count(8'hFF);
        send_frame(8'hFE, random_payload(255), 1'b1);
        random_traffic(300);

        send_idle_pct  = 74;
        recv_stall_pct = 10;
        write_func_count(8'h01);
        random_traffic(150);
        write_func_count(8'($urandom_range(254, 2)));
        random_traffic(250);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_func_count(FUNC_COUNT_RESET);
        random_traffic(300);

        drain();
        if (checker_h.errors == 0 && checker_h.pending() == 0) begin
            $display("crc8_frame_parser_top regression: pass");
        end else begin
            $display("crc8_frame_parser_top regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/crcfp_pkg.sv
rtl/crcfp_front.sv
rtl/crcfp_queue.sv
rtl/crcfp_back.sv
rtl/crc8_frame_parser_top.sv
tb/sv/crc8_frame_parser_top_test.sv
